/* rtl/mlhv_pkg.sv */
// Package for the masked label histogram vote block.
// Holds the controller states, the controller/datapath command and status
// structs and the register index and mode codes. No dependencies.
package mlhv_pkg;

    localparam int LABEL_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NUM_LABELS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SELECT_MODE = 2'd1;

    localparam logic MODE_MEDIAN  = 1'b0;
    localparam logic MODE_NOTZERO = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_UPD,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic pix_accept;
        logic upd_wr;
        logic clr_wr;
        logic scan_rd;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic pix_binned;
        logic pix_last;
        logic cnt_last;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/mlhv_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mlhv_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/mlhv_ctrl.sv */
// Controller state machine: reset clearing pass, pixel read-modify-write,
// histogram scan and result hand-off. Depends on mlhv_pkg.
module mlhv_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_last_pixel,
    output logic                 o_ready,
    input  mlhv_pkg::t_dp_status i_status,
    output mlhv_pkg::t_dp_cmd    o_cmd
);
    import mlhv_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.pix_accept = 1'b1;
                    if (i_status.pix_binned) begin
                        n_state = ST_UPD;
                    end else if (i_last_pixel) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_UPD: begin
                o_cmd.upd_wr = 1'b1;
                n_state = i_status.pix_last ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

`ifndef SYNTH
    a_upd_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> ($past(r_state) == ST_IDLE))
        else $error("write-back without a pixel transfer");

    a_scan_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ($past(r_state) == ST_SCAN || $past(r_state) == ST_IDLE
                                  || $past(r_state) == ST_UPD))
        else $error("scan entered from a wrong state");
`endif
endmodule

/* rtl/mlhv_dp.sv */
// Datapath: configuration registers, bin count memory, pixel counter,
// median and argmax accumulators, output register. Depends on mlhv_pkg, mlhv_ram.
module mlhv_dp #(
    parameter int MAX_LABELS = 256,
    parameter int COUNT_BITS = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [mlhv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mlhv_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [mlhv_pkg::LABEL_W-1:0]     i_pixel_label,
    input  logic                             i_in_mask,
    input  logic                             i_last_pixel,
    input  mlhv_pkg::t_dp_cmd                i_cmd,
    output mlhv_pkg::t_dp_status             o_status,
    output logic                             o_valid,
    output logic [mlhv_pkg::LABEL_W-1:0]     o_chosen_label,
    input  logic                             i_ready
);
    import mlhv_pkg::*;

    localparam int LBL_W = $clog2(MAX_LABELS);
    localparam int SUM_W = COUNT_BITS + LBL_W;
    localparam int NB_W  = CFG_DATA_W;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (v == '1) ? v : v + COUNT_BITS'(1);
    endfunction

    logic [NB_W-1:0]       r_num_labels;
    logic                  r_select_mode;
    logic [LBL_W-1:0]      r_pix_addr;
    logic                  r_pix_last;
    logic [COUNT_BITS-1:0] r_pix_cnt;
    logic [LBL_W-1:0]      r_cnt;
    logic                  r_proc_vld;
    logic [LBL_W-1:0]      r_proc_idx;
    logic [SUM_W-1:0]      r_running;
    logic                  r_med_found;
    logic [LBL_W-1:0]      r_med_idx;
    logic [LBL_W-1:0]      r_best_idx;
    logic [COUNT_BITS-1:0] r_best_v;
    logic [LBL_W-1:0]      r_alt_idx;
    logic [COUNT_BITS-1:0] r_alt_v;
    logic                  r_out_vld;
    logic [LABEL_W-1:0]    r_out_label;

    logic [NB_W-1:0]       nb_eff;
    logic [NB_W-1:0]       nb_m1;
    logic                  cnt_last;
    logic                  out_free;
    logic                  ram_we;
    logic [LBL_W-1:0]      ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [LBL_W-1:0]      ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic                  proc_in;
    logic [SUM_W-1:0]      run_sum;
    logic [COUNT_BITS-1:0] thresh;
    logic [LABEL_W-1:0]    chosen;

    always_comb begin
        if (r_num_labels == '0) begin
            nb_eff = NB_W'(1);
        end else if (r_num_labels > NB_W'(MAX_LABELS)) begin
            nb_eff = NB_W'(MAX_LABELS);
        end else begin
            nb_eff = r_num_labels;
        end
    end

    assign nb_m1    = nb_eff - NB_W'(1);
    assign cnt_last = (r_cnt == LBL_W'(MAX_LABELS - 1));
    assign out_free = !r_out_vld || i_ready;

    assign o_status.pix_binned = i_in_mask && (NB_W'(i_pixel_label) < nb_eff);
    assign o_status.pix_last   = r_pix_last;
    assign o_status.cnt_last   = cnt_last;
    assign o_status.out_free   = out_free;

    // memory ports
    assign ram_re    = i_cmd.pix_accept || i_cmd.scan_rd;
    assign ram_raddr = i_cmd.pix_accept ? i_pixel_label[LBL_W-1:0] : r_cnt;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_proc_idx;
        ram_wdata = '0;
        priority if (i_cmd.upd_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_pix_addr;
            ram_wdata = sat_inc(ram_rdata);
        end else if (i_cmd.clr_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_cnt;
        end else if (r_proc_vld) begin
            ram_we    = 1'b1;
            ram_waddr = r_proc_idx;
        end
    end

    mlhv_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_LABELS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // selection
    assign proc_in = r_proc_vld && (NB_W'(r_proc_idx) < nb_eff);
    assign run_sum = r_running + SUM_W'(ram_rdata);
    assign thresh  = (r_pix_cnt >> 1) + COUNT_BITS'(1);

    always_comb begin
        if (r_select_mode == MODE_NOTZERO) begin
            if (r_best_idx == '0 && r_best_v < r_pix_cnt) begin
                chosen = LABEL_W'(r_alt_idx);
            end else begin
                chosen = LABEL_W'(r_best_idx);
            end
        end else begin
            chosen = r_med_found ? LABEL_W'(r_med_idx) : nb_m1[LABEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_labels  <= NB_W'(256);
            r_select_mode <= MODE_MEDIAN;
            r_pix_last    <= 1'b0;
            r_pix_cnt     <= '0;
            r_cnt         <= '0;
            r_proc_vld    <= 1'b0;
            r_running     <= '0;
            r_med_found   <= 1'b0;
            r_best_idx    <= '0;
            r_best_v      <= '0;
            r_alt_idx     <= '0;
            r_alt_v       <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_IDX_NUM_LABELS:  r_num_labels  <= i_cfg_data;
                    CFG_IDX_SELECT_MODE: r_select_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_cmd.pix_accept) begin
                r_pix_last <= i_last_pixel;
                if (i_in_mask) begin
                    r_pix_cnt <= sat_inc(r_pix_cnt);
                end
            end

            if (i_cmd.scan_rd || i_cmd.clr_wr) begin
                r_cnt <= cnt_last ? '0 : r_cnt + LBL_W'(1);
            end
            r_proc_vld <= i_cmd.scan_rd;

            if (proc_in) begin
                r_running <= run_sum;
                if (!r_med_found && run_sum > SUM_W'(thresh)) begin
                    r_med_found <= 1'b1;
                end
                if (r_proc_idx == '0) begin
                    r_best_idx <= '0;
                    r_best_v   <= ram_rdata;
                end else begin
                    if (ram_rdata > r_best_v) begin
                        r_best_idx <= r_proc_idx;
                        r_best_v   <= ram_rdata;
                    end
                    if (ram_rdata > r_alt_v) begin
                        r_alt_idx <= r_proc_idx;
                        r_alt_v   <= ram_rdata;
                    end
                end
            end

            if (i_cmd.out_load) begin
                r_out_vld   <= 1'b1;
                r_pix_cnt   <= '0;
                r_running   <= '0;
                r_med_found <= 1'b0;
                r_best_idx  <= '0;
                r_best_v    <= '0;
                r_alt_idx   <= '0;
                r_alt_v     <= '0;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_accept) begin
            r_pix_addr <= i_pixel_label[LBL_W-1:0];
        end
        r_proc_idx <= r_cnt;
        if (proc_in && !r_med_found && run_sum > SUM_W'(thresh)) begin
            r_med_idx <= r_proc_idx;
        end
        if (i_cmd.out_load) begin
            r_out_label <= chosen;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_chosen_label = r_out_label;

`ifndef SYNTH
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_proc_vld |-> !i_cmd.upd_wr && !i_cmd.clr_wr)
        else $error("bin clear collides with another memory write");

    a_upd_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd_wr |-> $past(i_cmd.pix_accept))
        else $error("bin write-back without a preceding read");

    a_clear_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (r_pix_cnt == '0) && !r_med_found && r_out_vld)
        else $error("accumulators not cleared after selection");
`endif
endmodule

/* rtl/masked_label_histogram_vote.sv */
// Top level of the masked label histogram vote block.
// Depends on mlhv_pkg, mlhv_ctrl, mlhv_dp (which holds mlhv_ram).
//
//  channel   direction  handshake                payload
//  ------    ---------  -----------------------  ------------------------------------
//  pixel     in         i_valid / o_ready        i_pixel_label, i_in_mask, i_last_pixel
//  result    out        o_valid / i_ready        o_chosen_label
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A binned pixel takes a bin memory read when accepted, then a write-back of the
// incremented count in ST_UPD; a pixel that is not binned needs no write-back.
// A last pixel adds a scan of all MAX_LABELS bins through the memory read port,
// then ST_DRAIN and any wait in ST_DONE for the output register to drain.
// After reset a clearing pass over all MAX_LABELS bins zeroes them; o_ready
// stays low meanwhile. Config writes are taken in any cycle.
// The result sits in an output register; new pixels are taken while it waits.
module masked_label_histogram_vote #(
    parameter int MAX_LABELS = 256,
    parameter int COUNT_BITS = 20
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mlhv_pkg::LABEL_W-1:0]    i_pixel_label,
    input  logic                            i_in_mask,
    input  logic                            i_last_pixel,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mlhv_pkg::LABEL_W-1:0]    o_chosen_label,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mlhv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mlhv_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mlhv_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    mlhv_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_last_pixel (i_last_pixel),
        .o_ready      (o_ready),
        .i_status     (dp_status),
        .o_cmd        (dp_cmd)
    );

    mlhv_dp #(
        .MAX_LABELS (MAX_LABELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pixel_label  (i_pixel_label),
        .i_in_mask      (i_in_mask),
        .i_last_pixel   (i_last_pixel),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .o_valid        (o_valid),
        .o_chosen_label (o_chosen_label),
        .i_ready        (i_ready)
    );
endmodule

/* dv/masked_label_histogram_vote_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for masked_label_histogram_vote: streams superpixels,
// writes the bin count and selection mode between phases and checks each vote.
// Depends on mlhv_pkg and the RTL top level.
module masked_label_histogram_vote_tb;
    import mlhv_pkg::*;

    localparam int MAX_LABELS   = 256;
    localparam int COUNT_BITS   = 20;
    localparam int COUNT_SAT    = (1 << COUNT_BITS) - 1;
    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic               in_mask;
        logic               last;
    } t_pixel;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_valid        = 1'b0;
    logic                  o_ready;
    logic [LABEL_W-1:0]    i_pixel_label  = '0;
    logic                  i_in_mask      = 1'b0;
    logic                  i_last_pixel   = 1'b0;
    logic                  o_valid;
    logic                  i_ready        = 1'b0;
    logic [LABEL_W-1:0]    o_chosen_label;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    t_pixel                pixel_fifo[$];
    logic [LABEL_W-1:0]    expected_labels[$];
    int                    label_hist[MAX_LABELS] = '{default: 0};
    int                    masked_total   = 0;
    logic [CFG_DATA_W-1:0] cfg_num_labels = 9'd256;
    logic                  cfg_mode       = MODE_MEDIAN;
    logic                  calm           = 1'b0;
    int                    send_gap       = 0;
    int                    recv_hold      = 0;
    int                    mismatches     = 0;
    int                    cycles         = 0;

    masked_label_histogram_vote #(
        .MAX_LABELS(MAX_LABELS),
        .COUNT_BITS(COUNT_BITS)
    ) DUT (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int bins_in_use(input logic [CFG_DATA_W-1:0] nl);
        if (nl == 0) return 1;
        if (nl > MAX_LABELS) return MAX_LABELS;
        return int'(nl);
    endfunction

    function automatic void tally_pixel(input t_pixel px);
        int nb;
        int thr;
        int run;
        int best;
        int bestv;
        int alt;
        int altv;
        bit found;
        nb = bins_in_use(cfg_num_labels);
        if (px.in_mask) begin
            if (masked_total < COUNT_SAT) masked_total++;
            if (px.label < nb && label_hist[px.label] < COUNT_SAT) label_hist[px.label]++;
        end
        if (!px.last) return;
        if (cfg_mode == MODE_NOTZERO) begin
            best  = 0;
            bestv = label_hist[0];
            for (int b = 1; b < nb; b++) begin
                if (label_hist[b] > bestv) begin
                    best  = b;
                    bestv = label_hist[b];
                end
            end
            if (best == 0 && bestv < masked_total) begin
                alt  = 0;
                altv = 0;
                for (int b = 1; b < nb; b++) begin
                    if (label_hist[b] > altv) begin
                        alt  = b;
                        altv = label_hist[b];
                    end
                end
                best = alt;
            end
        end else begin
            thr   = masked_total / 2 + 1;
            run   = 0;
            best  = nb - 1;
            found = 1'b0;
            for (int b = 0; b < nb && !found; b++) begin
                run += label_hist[b];
                if (run > thr) begin
                    best  = b;
                    found = 1'b1;
                end
            end
        end
        expected_labels.push_back(LABEL_W'(best));
        label_hist   = '{default: 0};
        masked_total = 0;
    endfunction

    function automatic void queue_pixel(input int label, input bit mask, input bit last);
        pixel_fifo.push_back(t_pixel'{LABEL_W'(label), mask, last});
    endfunction

    always @(posedge i_clk) begin : pixel_driver
        t_pixel nxt;
        logic   vld_n;
        int     gap_n;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            vld_n = i_valid;
            gap_n = send_gap;
            if (i_valid && o_ready) begin
                tally_pixel(t_pixel'{i_pixel_label, i_in_mask, i_last_pixel});
                vld_n = 1'b0;
                gap_n = calm ? 0 : $urandom_range(0, 8);
            end
            if (!vld_n) begin
                if (gap_n > 0) begin
                    gap_n--;
                end else if (pixel_fifo.size() != 0) begin
                    nxt           = pixel_fifo.pop_front();
                    vld_n         = 1'b1;
                    i_pixel_label <= nxt.label;
                    i_in_mask     <= nxt.in_mask;
                    i_last_pixel  <= nxt.last;
                end
            end
            i_valid  <= vld_n;
            send_gap <= gap_n;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        logic [LABEL_W-1:0] want;
        int                 hold_n;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            recv_hold <= 0;
        end else begin
            hold_n = recv_hold;
            if (o_valid && i_ready) begin
                if (expected_labels.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected transfer: chosen_label %0d", o_chosen_label);
                    mismatches++;
                end else begin
                    want = expected_labels.pop_front();
                    if (o_chosen_label !== want) begin
                        if (mismatches < 10)
                            $display("chosen_label mismatch: expected %0d, got %0d",
                                     want, o_chosen_label);
                        mismatches++;
                    end
                end
                hold_n = calm ? 0 : $urandom_range(0, 8);
            end else if (hold_n > 0) begin
                hold_n--;
            end
            i_ready   <= (hold_n == 0);
            recv_hold <= hold_n;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic settle();
        while (pixel_fifo.size() != 0 || i_valid || expected_labels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IDX_NUM_LABELS:  cfg_num_labels = data;
            CFG_IDX_SELECT_MODE: cfg_mode = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_superpixel(input int len, input int nb, input bit close);
        int palette[4];
        int lim;
        int lbl;
        bit all_in;
        lim    = (nb >= 255) ? 255 : nb + 1;
        all_in = ($urandom_range(0, 3) == 0);
        foreach (palette[k]) palette[k] = $urandom_range(0, lim);
        if ($urandom_range(0, 2) == 0) palette[0] = 0;
        for (int k = 0; k < len; k++) begin
            lbl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                              : palette[$urandom_range(0, 3)];
            queue_pixel(lbl, all_in || $urandom_range(0, 3) != 0, close && k == len - 1);
        end
    endtask

    initial begin : stimulus
        int   sent;
        int   phase_end;
        int   len;
        int   nl;
        int   nb;
        int   lbl;
        bit   sat_done;
        logic mode_bit;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_IDX_NUM_LABELS, 9'd256);
        write_reg(CFG_IDX_SELECT_MODE, {8'h00, MODE_MEDIAN});
        write_reg(CFG_IDX_SPARE, 9'h1ff);
        // empty superpixel, lone top label, median just past a heavy bin 0,
        // last pixel out of mask
        queue_pixel(0, 0, 1);
        queue_pixel(255, 1, 1);
        queue_pixel(0, 1, 0);
        queue_pixel(0, 1, 0);
        queue_pixel(0, 1, 0);
        queue_pixel(7, 1, 1);
        queue_pixel(200, 1, 0);
        queue_pixel(200, 1, 0);
        queue_pixel(200, 0, 1);
        settle();

        // bin 0 leads but yields to the other label, all-zero superpixel, empty superpixel, tie
        write_reg(CFG_IDX_SELECT_MODE, {8'hff, MODE_NOTZERO});
        queue_pixel(0, 1, 0);
        queue_pixel(0, 1, 0);
        queue_pixel(5, 1, 1);
        queue_pixel(0, 1, 0);
        queue_pixel(0, 1, 1);
        queue_pixel(9, 0, 1);
        queue_pixel(3, 1, 0);
        queue_pixel(9, 1, 0);
        queue_pixel(9, 1, 0);
        queue_pixel(3, 1, 1);
        settle();

        // zero bins act as one; leave a pixel open across the next write
        write_reg(CFG_IDX_NUM_LABELS, 9'd0);
        write_reg(CFG_IDX_SELECT_MODE, {8'h00, MODE_MEDIAN});
        queue_pixel(0, 1, 0);
        queue_pixel(200, 1, 1);
        queue_pixel(1, 1, 0);
        settle();

        write_reg(CFG_IDX_NUM_LABELS, 9'h1ff);
        write_reg(CFG_IDX_SELECT_MODE, {8'h5a, MODE_NOTZERO});
        queue_pixel(255, 1, 0);
        queue_pixel(255, 1, 1);

        sent     = 0;
        sat_done = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            calm <= ($urandom_range(0, 3) == 0);
            if (!sat_done && sent >= 200) begin
                nl = 256;
            end else begin
                case ($urandom_range(0, 5))
                    0:       nl = 1;
                    1:       nl = 256;
                    2:       nl = $urandom_range(257, 511);
                    3:       nl = 0;
                    4:       nl = $urandom_range(2, 16);
                    default: nl = $urandom_range(1, 256);
                endcase
            end
            mode_bit = ($urandom_range(0, 1) == 1) ? MODE_NOTZERO : MODE_MEDIAN;
            write_reg(CFG_IDX_NUM_LABELS, CFG_DATA_W'(nl));
            write_reg(CFG_IDX_SELECT_MODE, {8'($urandom), mode_bit});
            nb = bins_in_use(CFG_DATA_W'(nl));
            if (!sat_done && sent >= 200) begin
                // one long superpixel dominated by a single label
                lbl = $urandom_range(0, 255);
                for (int k = 0; k < 300; k++)
                    queue_pixel((k % 16 == 15) ? $urandom_range(0, 255) : lbl, 1'b1, k == 299);
                sent    += 300;
                sat_done = 1'b1;
            end else begin
                phase_end = sent + $urandom_range(20, 80);
                while (sent < phase_end) begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48)
                                                      : $urandom_range(1, 16);
                    add_superpixel(len, nb,
                                   $urandom_range(0, 5) != 0 || sent + len < phase_end);
                    sent += len;
                end
            end
        end

        settle();
        repeat (MAX_LABELS + DRAIN_CYCLES) @(posedge i_clk);
        if (expected_labels.size() != 0) begin
            $display("%0d chosen labels never arrived", expected_labels.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
